FILE: rtl/mrc_pkg.sv
// Package for the Modbus RTU response checker.
// Word types, phase and status codes, register indexes and the CRC-16 byte step.
// Used by every file in rtl/.
package mrc_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       last;
  } out_t;

  // up to two result words pushed by one accepted input word
  typedef struct packed {
    logic vld0;
    logic vld1;
    out_t word0;
    out_t word1;
  } push_t;

  typedef enum logic [2:0] {
    PH_ADDR,
    PH_FUNC,
    PH_COUNT,
    PH_DATA,
    PH_CRCLO,
    PH_CRCHI,
    PH_DONE
  } phase_e;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_FUNC  = 3'd2;
  localparam logic [2:0] ST_SHORT = 3'd3;
  localparam logic [2:0] ST_CRC   = 3'd4;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_FUNC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 2'd2;

  localparam logic [7:0] RST_EXP_ADDR = 8'd1;
  localparam logic [6:0] RST_EXP_FUNC = 7'd3;
  localparam logic       RST_SWAP     = 1'b1;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam int FIFO_DEPTH = 4;

  // one byte of CRC-16 (reflected), eight shift/xor steps
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/mrc_out_fifo.sv
// Result queue of the Modbus RTU response checker: takes up to two words a cycle,
// hands out one word a cycle while out_stall_i is low, on a valid/stall channel.
// Depends on mrc_pkg.
module mrc_out_fifo #(
  parameter int Depth = mrc_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mrc_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  output mrc_pkg::out_t  out_data_o,
  input  logic           out_stall_i
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  mrc_pkg::out_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW-1:0] wptr_nx1, wptr_nx2;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      push_n;
  logic            pop;

  always_comb begin
    wptr_nx1 = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    wptr_nx2 = (wptr_nx1 == LastPtr) ? '0 : wptr_nx1 + 1'b1;
    push_n   = {1'b0, push_i.vld0} + {1'b0, push_i.vld1};
    pop      = (cnt_q != '0) && !out_stall_i;
    if (push_i.vld1) begin
      wptr_d = wptr_nx2;
    end else if (push_i.vld0) begin
      wptr_d = wptr_nx1;
    end else begin
      wptr_d = wptr_q;
    end
    if (pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end else begin
      rptr_d = rptr_q;
    end
    cnt_d = cnt_q + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wptr_q] <= push_i.word0;
    end
    if (push_i.vld1) begin
      mem_q[wptr_nx1] <= push_i.word1;
    end
  end

  // two free slots needed, an input word may push two results
  assign room_o      = cnt_q <= CntW'(Depth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rptr_q];

endmodule

FILE: rtl/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU response checker: configuration registers,
// frame parser with CRC-16 and pair swap, result queue.
// Depends on mrc_pkg and mrc_out_fifo.
//
// Usage:
//   Input channel (in_valid_i / in_data_i / in_stall_o): one word per received
//   byte (op = 0) or an idle-line marker (op = 1) that closes the frame.
//   Output channel (out_valid_o / out_data_o / out_stall_i): data bytes
//   (kind = 0) in output order, then one status word (kind = 1, last = 1).
//   A frame is parsed as address, function, byte count, data, CRC low, CRC high.
//   Words are checked and the CRC updated in the cycle they are accepted; the
//   results are registered in a FifoDepth-word queue before they can leave.
//   Throughput: one input word per cycle while in_stall_o is low; a data byte
//   that completes a pair pushes two results, so sustained rate is set by the
//   one-word-per-cycle output port (while out_stall_i is low) draining the queue.
//   in_stall_o rises when fewer than two queue slots are free, so a stalled
//   receiver backs up into the input side after the queue fills; nothing is lost.
//   Reset: parser returns to awaiting the address byte, CRC preset to all ones,
//   queue empty, registers back to address 1, function 3, pair swap on. Configuration
//   (cfg_we_i/cfg_idx_i/cfg_data_i) is written by the user only while idle, unchecked.
module modbus_rtu_response_checker #(
  parameter int FifoDepth = mrc_pkg::FIFO_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  mrc_pkg::in_t                    in_data_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output mrc_pkg::out_t                   out_data_o,
  input  logic                            out_stall_i,
  input  logic                            cfg_we_i,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mrc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [7:0] exp_addr_q;
  logic [6:0] exp_func_q;
  logic       swap_q;

  mrc_pkg::phase_e phase_q, phase_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic [8:0]  bytes_seen_q, bytes_seen_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        held_valid_q, held_valid_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [2:0]  err_q, err_d;

  logic           accept;
  logic           room;
  logic           is_byte;
  logic           is_idle;
  logic [7:0]     rx;
  logic [15:0]    crc_next;
  logic [9:0]     seen_inc;
  logic           final_byte;
  mrc_pkg::push_t push;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = !room;
  assign is_byte    = accept && (in_data_i.op == mrc_pkg::OP_BYTE);
  assign is_idle    = accept && (in_data_i.op == mrc_pkg::OP_IDLE);
  assign rx         = in_data_i.rx_byte;
  assign crc_next   = mrc_pkg::crc16_byte(crc_q, rx);
  assign seen_inc   = {1'b0, bytes_seen_q} + 10'd1;
  assign final_byte = seen_inc >= {2'b00, byte_count_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= mrc_pkg::RST_EXP_ADDR;
      exp_func_q <= mrc_pkg::RST_EXP_FUNC;
      swap_q     <= mrc_pkg::RST_SWAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrc_pkg::CFG_EXP_ADDR: exp_addr_q <= cfg_data_i;
        mrc_pkg::CFG_EXP_FUNC: exp_func_q <= cfg_data_i[6:0];
        mrc_pkg::CFG_SWAP:     swap_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (is_idle) begin
      phase_d = mrc_pkg::PH_ADDR;
    end else if (is_byte) begin
      case (phase_q)
        mrc_pkg::PH_ADDR:  phase_d = mrc_pkg::PH_FUNC;
        mrc_pkg::PH_FUNC:  phase_d = mrc_pkg::PH_COUNT;
        mrc_pkg::PH_COUNT: phase_d = (rx == 8'd0) ? mrc_pkg::PH_CRCLO : mrc_pkg::PH_DATA;
        mrc_pkg::PH_DATA:  phase_d = final_byte ? mrc_pkg::PH_CRCLO : mrc_pkg::PH_DATA;
        mrc_pkg::PH_CRCLO: phase_d = mrc_pkg::PH_CRCHI;
        mrc_pkg::PH_CRCHI: phase_d = mrc_pkg::PH_DONE;
        default:           phase_d = phase_q;
      endcase
    end
  end

  // datapath and results
  always_comb begin
    byte_count_d = byte_count_q;
    bytes_seen_d = bytes_seen_q;
    crc_d        = crc_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    crc_lo_d     = crc_lo_q;
    err_d        = err_q;
    push         = '0;
    push.word0.kind      = mrc_pkg::KIND_DATA;
    push.word0.data_byte = rx;
    push.word1.kind      = mrc_pkg::KIND_DATA;
    push.word1.data_byte = held_byte_q;

    if (is_idle) begin
      // idle before any byte is ignored
      if (phase_q != mrc_pkg::PH_ADDR) begin
        push.vld0         = 1'b1;
        push.word0.kind   = mrc_pkg::KIND_STATUS;
        push.word0.data_byte = 8'd0;
        push.word0.last   = 1'b1;
        push.word0.status = (phase_q != mrc_pkg::PH_DONE && err_q == mrc_pkg::ST_OK) ?
                            mrc_pkg::ST_SHORT : err_q;
        byte_count_d = '0;
        bytes_seen_d = '0;
        crc_d        = mrc_pkg::CRC_PRESET;
        held_byte_d  = '0;
        held_valid_d = 1'b0;
        crc_lo_d     = '0;
        err_d        = mrc_pkg::ST_OK;
      end
    end else if (is_byte) begin
      case (phase_q)
        mrc_pkg::PH_ADDR: begin
          if (rx != exp_addr_q && err_q == mrc_pkg::ST_OK) begin
            err_d = mrc_pkg::ST_ADDR;
          end
          crc_d = crc_next;
        end
        mrc_pkg::PH_FUNC: begin
          if (rx != {1'b0, exp_func_q} && err_q == mrc_pkg::ST_OK) begin
            err_d = mrc_pkg::ST_FUNC;
          end
          crc_d = crc_next;
        end
        mrc_pkg::PH_COUNT: begin
          byte_count_d = rx;
          bytes_seen_d = '0;
          crc_d        = crc_next;
        end
        mrc_pkg::PH_DATA: begin
          crc_d        = crc_next;
          bytes_seen_d = seen_inc[8:0];
          if (held_valid_q) begin
            // second byte of a pair goes out first
            push.vld0    = 1'b1;
            push.vld1    = 1'b1;
            held_valid_d = 1'b0;
            held_byte_d  = '0;
          end else if (swap_q && !final_byte) begin
            held_byte_d  = rx;
            held_valid_d = 1'b1;
          end else begin
            push.vld0 = 1'b1;
          end
        end
        mrc_pkg::PH_CRCLO: begin
          crc_lo_d = rx;
        end
        mrc_pkg::PH_CRCHI: begin
          if ((crc_lo_q != crc_q[7:0] || rx != crc_q[15:8]) && err_q == mrc_pkg::ST_OK) begin
            err_d = mrc_pkg::ST_CRC;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= mrc_pkg::PH_ADDR;
      byte_count_q <= '0;
      bytes_seen_q <= '0;
      crc_q        <= mrc_pkg::CRC_PRESET;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      crc_lo_q     <= '0;
      err_q        <= mrc_pkg::ST_OK;
    end else begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      bytes_seen_q <= bytes_seen_d;
      crc_q        <= crc_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      crc_lo_q     <= crc_lo_d;
      err_q        <= err_d;
    end
  end

  mrc_out_fifo #(
    .Depth(FifoDepth)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

`ifndef NO_ASSERTIONS
  // a byte is only held for swapping inside the data field
  a_held_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> phase_q == mrc_pkg::PH_DATA)
    else $error("held byte outside data phase");

  // a status word closes the frame and clears the parser
  a_status_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_idle && phase_q != mrc_pkg::PH_ADDR) |=>
      (phase_q == mrc_pkg::PH_ADDR && !held_valid_q && err_q == mrc_pkg::ST_OK &&
       crc_q == mrc_pkg::CRC_PRESET))
    else $error("parser not cleared after status");

  // a CRC error can only exist once the CRC high byte was seen
  a_crc_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q == mrc_pkg::ST_CRC |-> phase_q == mrc_pkg::PH_DONE)
    else $error("crc error before frame end");
`endif

endmodule
